FILE: hdl/qsu_pkg.sv
package qsu_pkg;

  // One input request: a data byte or the end-of-data marker.
  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
  } item_t;

  // One decoded result.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last_of_run;
  } result_t;

  localparam int MAX_RESULTS = 3;

  // All results that one request causes, in order, with their count.
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] slot;
    logic    [1:0]             count;
  } res_bundle_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_STR  = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX  = 3'd3,
    MODE_OCT  = 3'd4
  } mode_t;

  localparam logic       KIND_DATA = 1'b0;
  localparam logic       KIND_END  = 1'b1;

  localparam logic [1:0] ST_DATA    = 2'd0;
  localparam logic [1:0] ST_CLOSED  = 2'd1;
  localparam logic [1:0] ST_BAD_HEX = 2'd2;
  localparam logic [1:0] ST_UNTERM  = 2'd3;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [15:0] UTF8_MAX1  = 16'h007F;
  localparam logic [15:0] UTF8_MAX2  = 16'h07FF;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [15:0] MASK_2_HI  = 16'h07C0;
  localparam logic [15:0] MASK_3_HI  = 16'hF000;
  localparam logic [15:0] MASK_3_MID = 16'h0FC0;
  localparam logic [15:0] MASK_LOW6  = 16'h003F;

endpackage

FILE: hdl/qsu_parse.sv
module qsu_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  qsu_pkg::item_t      item,
  output qsu_pkg::res_bundle_t bundle
);
  import qsu_pkg::*;

  typedef struct packed {
    mode_t       mode;
    logic        quote_is_single;
    logic [2:0]  digit_count;
    logic [15:0] escape_value;
    logic        hex_is_unicode;
  } state_t;

  state_t      st;
  state_t      st_next;
  res_bundle_t bd;
  logic [7:0]  b;
  logic [7:0]  q;
  logic        at_end;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic        is_oct;
  logic [15:0] hex_acc;
  logic [2:0]  cnt_inc;

  function automatic res_bundle_t push(res_bundle_t d, logic [7:0] byt, logic [1:0] stat);
    res_bundle_t r;
    r = d;
    r.slot[r.count].out_byte    = (stat == ST_DATA) ? byt : 8'h00;
    r.slot[r.count].status      = stat;
    r.slot[r.count].last_of_run = 1'b0;
    r.count = r.count + 2'd1;
    return r;
  endfunction

  function automatic res_bundle_t push_utf8(res_bundle_t d, logic [15:0] v);
    res_bundle_t r;
    r = d;
    if (v <= UTF8_MAX1) begin
      r = push(r, v[7:0], ST_DATA);
    end else if (v <= UTF8_MAX2) begin
      r = push(r, UTF8_LEAD2 + 8'((v & MASK_2_HI) >> 6), ST_DATA);
      r = push(r, UTF8_CONT + 8'(v & MASK_LOW6), ST_DATA);
    end else begin
      r = push(r, UTF8_LEAD3 + 8'((v & MASK_3_HI) >> 12), ST_DATA);
      r = push(r, UTF8_CONT + 8'((v & MASK_3_MID) >> 6), ST_DATA);
      r = push(r, UTF8_CONT + 8'(v & MASK_LOW6), ST_DATA);
    end
    return r;
  endfunction

  assign b       = item.in_byte;
  assign at_end  = (item.kind == KIND_END);
  assign q       = st.quote_is_single ? CH_SQUOTE : CH_DQUOTE;
  assign is_oct  = (b >= "0") && (b <= "7");
  assign hex_acc = {st.escape_value[11:0], hex_val};
  assign cnt_inc = st.digit_count + 3'd1;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if ((b >= "0") && (b <= "9")) begin
      hex_val = 4'(b - "0");
    end else if ((b >= "a") && (b <= "f")) begin
      hex_val = 4'(b - "a" + 8'd10);
    end else if ((b >= "A") && (b <= "F")) begin
      hex_val = 4'(b - "A" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    st_next = st;
    bd      = '0;
    unique case (st.mode)
      MODE_STR: begin
        if (at_end) begin
          bd = push(bd, 8'h00, ST_UNTERM);
          st_next.mode = MODE_IDLE;
        end else if (b == q) begin
          bd = push(bd, 8'h00, ST_CLOSED);
          st_next.mode = MODE_IDLE;
        end else if (b == CH_BSLASH) begin
          st_next.mode = MODE_ESC;
        end else begin
          bd = push(bd, b, ST_DATA);
        end
      end
      MODE_ESC: begin
        if (at_end) begin
          bd = push(bd, 8'h00, ST_UNTERM);
          st_next.mode = MODE_IDLE;
        end else begin
          st_next.mode = MODE_STR;
          case (b) inside
            "u", "x": begin
              st_next.mode           = MODE_HEX;
              st_next.hex_is_unicode = (b == "u");
              st_next.digit_count    = 3'd0;
              st_next.escape_value   = 16'h0000;
            end
            ["0":"7"]: begin
              st_next.mode         = MODE_OCT;
              st_next.digit_count  = 3'd1;
              st_next.escape_value = {13'd0, b[2:0]};
            end
            CH_DQUOTE, CH_SQUOTE: begin
              if (b != q) begin
                bd = push(bd, CH_BSLASH, ST_DATA);
              end
              bd = push(bd, b, ST_DATA);
            end
            "/":       bd = push(bd, "/", ST_DATA);
            CH_BSLASH: bd = push(bd, CH_BSLASH, ST_DATA);
            "b":       bd = push(bd, 8'h08, ST_DATA);
            "f":       bd = push(bd, 8'h0C, ST_DATA);
            "r":       bd = push(bd, 8'h0D, ST_DATA);
            "n":       bd = push(bd, 8'h0A, ST_DATA);
            "t":       bd = push(bd, 8'h09, ST_DATA);
            "v":       bd = push(bd, 8'h0B, ST_DATA);
            "a":       bd = push(bd, 8'h07, ST_DATA);
            default: begin
              bd = push(bd, CH_BSLASH, ST_DATA);
              bd = push(bd, b, ST_DATA);
            end
          endcase
        end
      end
      MODE_HEX: begin
        if (at_end || !hex_ok) begin
          bd = push(bd, 8'h00, ST_BAD_HEX);
          st_next.mode = MODE_IDLE;
        end else begin
          st_next.escape_value = hex_acc;
          st_next.digit_count  = cnt_inc;
          if (cnt_inc >= (st.hex_is_unicode ? 3'd4 : 3'd2)) begin
            if (st.hex_is_unicode) begin
              bd = push_utf8(bd, hex_acc);
            end else begin
              bd = push(bd, hex_acc[7:0], ST_DATA);
            end
            st_next.mode = MODE_STR;
          end
        end
      end
      MODE_OCT: begin
        if (at_end) begin
          bd = push_utf8(bd, st.escape_value);
          bd = push(bd, 8'h00, ST_UNTERM);
          st_next.mode = MODE_IDLE;
        end else if (is_oct && (st.digit_count < 3'd3)) begin
          st_next.escape_value = {st.escape_value[12:0], b[2:0]};
          st_next.digit_count  = cnt_inc;
          if (cnt_inc >= 3'd3) begin
            bd = push_utf8(bd, {st.escape_value[12:0], b[2:0]});
            st_next.mode = MODE_STR;
          end
        end else begin
          // The run is over: flush its value, then treat the byte as string text.
          bd = push_utf8(bd, st.escape_value);
          st_next.mode = MODE_STR;
          if (b == q) begin
            bd = push(bd, 8'h00, ST_CLOSED);
            st_next.mode = MODE_IDLE;
          end else if (b == CH_BSLASH) begin
            st_next.mode = MODE_ESC;
          end else begin
            bd = push(bd, b, ST_DATA);
          end
        end
      end
      default: begin
        st_next.mode = MODE_IDLE;
        if (!at_end && ((b == CH_DQUOTE) || (b == CH_SQUOTE))) begin
          st_next.quote_is_single = (b == CH_SQUOTE);
          st_next.mode            = MODE_STR;
        end
      end
    endcase
    for (int i = 0; i < MAX_RESULTS; i++) begin
      bd.slot[i].last_of_run = (bd.count != 2'd0) && (2'(i) == (bd.count - 2'd1));
    end
  end

  assign bundle = bd;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode            <= MODE_IDLE;
      st.quote_is_single <= 1'b0;
      st.digit_count     <= 3'd0;
      st.escape_value    <= 16'h0000;
      st.hex_is_unicode  <= 1'b0;
    end else if (take) begin
      st <= st_next;
    end
  end

endmodule

FILE: hdl/qsu_out_buf.sv
module qsu_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  qsu_pkg::res_bundle_t bundle,
  output logic                 room,
  output logic                 result_valid,
  input  logic                 result_stall,
  output qsu_pkg::result_t     result
);
  import qsu_pkg::*;

  result_t [MAX_RESULTS-1:0] slots;
  logic [1:0] cnt;
  logic [1:0] rd;
  logic       taken;

  assign result_valid = (cnt != 2'd0);
  assign result       = slots[rd];
  assign taken        = result_valid && !result_stall;
  // Room for a new run once the pending one is gone or its last result leaves now.
  assign room         = (cnt == 2'd0) || ((cnt == 2'd1) && !result_stall);

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= bundle.slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      rd  <= 2'd0;
    end else if (load) begin
      cnt <= bundle.count;
      rd  <= 2'd0;
    end else if (taken) begin
      cnt <= cnt - 2'd1;
      rd  <= (cnt == 2'd1) ? 2'd0 : rd + 2'd1;
    end
  end

endmodule

FILE: hdl/quoted_string_unescape_utf8.sv
// Quoted-string unescaper with UTF-8 output.
// A request's first result is offered in the cycle after it is accepted.
// Throughput: one request per cycle unless stalled; a request causing n
// results holds the next while the buffer drains them one per cycle.
// Reset: synchronous, active high; returns to idle outside any string and
// discards any results not yet delivered.
module quoted_string_unescape_utf8 (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  qsu_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output qsu_pkg::result_t result
);
  import qsu_pkg::*;

  // The parser holds the lexer state and decodes each accepted request in
  // one pass into up to three results, which the buffer then hands out in
  // order, one per cycle unless stalled. It takes a new run in the same cycle
  // its final pending result leaves, so plain text streams without gaps.
  res_bundle_t bundle;
  logic        room;
  logic        accept;

  assign item_stall = !room;
  assign accept     = item_valid && room;

  qsu_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .take   (accept),
    .item   (item),
    .bundle (bundle)
  );

  // Requests that cause no result (idle bytes, opening quotes, escape
  // prefixes) only move the parser state and never touch the buffer.
  qsu_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .load         (accept && (bundle.count != 2'd0)),
    .bundle       (bundle),
    .room         (room),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // A new request is taken only when no earlier result would be overwritten.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!result_valid || (result.last_of_run && !result_stall)))
    else $error("request accepted while earlier results were pending");

  // Status results always end their run.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status != ST_DATA)) |-> result.last_of_run)
    else $error("status result not marked last of run");

  // Status results carry a zero byte.
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status != ST_DATA)) |-> (result.out_byte == 8'h00))
    else $error("status result with nonzero byte");

  // After a non-final result is taken, another result of the run follows.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && !result.last_of_run) |=> result_valid)
    else $error("run ended without a last result");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import qsu_pkg::*;

  // One request waiting to be sent. When hold_until_drained is set, the
  // sender keeps its valid low until every predicted byte has arrived.
  typedef struct {
    item_t req;
    bit    hold_until_drained;
  } pending_req_t;

  localparam logic [7:0] ESC_UNICODE = "u";
  localparam logic [7:0] ESC_RAW     = "x";
  localparam logic [7:0] CH_SLASH    = "/";
  localparam string      NAMED_ESC   = "\"'/\\bfrntva";
  localparam string      KNOWN_ESC   = "\"'/\\bfrntvaux01234567";

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  pending_req_t pending_q[$];
  result_t      decoded_q[$];
  result_t      step_bytes[$];

  int  total_reqs = 0;
  int  accepted_cnt = 0;
  int  failures = 0;
  bit  req_taken = 1'b0;

  // Decoder state as the testbench tracks it.
  mode_t       dec_mode = MODE_IDLE;
  logic        dec_single = 1'b0;
  logic [2:0]  dec_ndig = '0;
  logic [15:0] dec_acc = '0;
  logic        dec_is_u = 1'b0;

  quoted_string_unescape_utf8 dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------

  // Appends one result for the current request. The byte field only carries
  // data for plain bytes; status results carry zero there.
  function automatic void put_byte(input logic [15:0] val, input logic [1:0] st);
    result_t r;
    r.out_byte    = (st == ST_DATA) ? val[7:0] : 8'h00;
    r.status      = st;
    r.last_of_run = 1'b0;
    step_bytes = {step_bytes, r};
  endfunction

  // Encodes a code point of up to 16 bits as one to three UTF-8 bytes.
  function automatic void put_utf8(input logic [15:0] v);
    if (v <= UTF8_MAX1) begin
      put_byte(v, ST_DATA);
    end else if (v <= UTF8_MAX2) begin
      put_byte(UTF8_LEAD2 + ((v & MASK_2_HI) >> 6), ST_DATA);
      put_byte(UTF8_CONT + (v & MASK_LOW6), ST_DATA);
    end else begin
      put_byte(UTF8_LEAD3 + ((v & MASK_3_HI) >> 12), ST_DATA);
      put_byte(UTF8_CONT + ((v & MASK_3_MID) >> 6), ST_DATA);
      put_byte(UTF8_CONT + (v & MASK_LOW6), ST_DATA);
    end
  endfunction

  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = '0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "a" && c <= "f") begin
      v = 4'(c - "a" + 10);
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // A byte inside the string body: the matching quote closes it, a
  // backslash opens an escape, anything else is copied.
  function automatic void string_char(input logic [7:0] b);
    logic [7:0] q;
    q = dec_single ? CH_SQUOTE : CH_DQUOTE;
    if (b == q) begin
      put_byte(16'h0, ST_CLOSED);
      dec_mode = MODE_IDLE;
    end else if (b == CH_BSLASH) begin
      dec_mode = MODE_ESC;
    end else begin
      put_byte({8'h00, b}, ST_DATA);
    end
  endfunction

  // The byte right after a backslash.
  function automatic void escape_char(input logic [7:0] b);
    logic [7:0] q;
    q = dec_single ? CH_SQUOTE : CH_DQUOTE;
    dec_mode = MODE_STR;
    case (b)
      ESC_UNICODE, ESC_RAW: begin
        dec_mode = MODE_HEX;
        dec_is_u = (b == ESC_UNICODE);
        dec_ndig = '0;
        dec_acc  = '0;
      end
      "0", "1", "2", "3", "4", "5", "6", "7": begin
        dec_mode = MODE_OCT;
        dec_ndig = 3'd1;
        dec_acc  = {13'h0, b[2:0]};
      end
      CH_DQUOTE, CH_SQUOTE: begin
        // The quote of the other kind keeps its backslash.
        if (b != q) put_byte({8'h00, CH_BSLASH}, ST_DATA);
        put_byte({8'h00, b}, ST_DATA);
      end
      CH_SLASH, CH_BSLASH: put_byte({8'h00, b}, ST_DATA);
      "b": put_byte(16'h08, ST_DATA);
      "f": put_byte(16'h0C, ST_DATA);
      "r": put_byte(16'h0D, ST_DATA);
      "n": put_byte(16'h0A, ST_DATA);
      "t": put_byte(16'h09, ST_DATA);
      "v": put_byte(16'h0B, ST_DATA);
      "a": put_byte(16'h07, ST_DATA);
      default: begin
        // Unknown escapes pass through with their backslash.
        put_byte({8'h00, CH_BSLASH}, ST_DATA);
        put_byte({8'h00, b}, ST_DATA);
      end
    endcase
  endfunction

  // Works out every result one accepted request causes and queues them,
  // flagging the final one of the run.
  function automatic void decode_request(input item_t req);
    logic       at_end;
    logic [7:0] b;
    logic [3:0] d;
    at_end = (req.kind == KIND_END);
    b = req.in_byte;
    step_bytes.delete();
    case (dec_mode)
      MODE_STR, MODE_ESC: begin
        if (at_end) begin
          put_byte(16'h0, ST_UNTERM);
          dec_mode = MODE_IDLE;
        end else if (dec_mode == MODE_STR) begin
          string_char(b);
        end else begin
          escape_char(b);
        end
      end
      MODE_HEX: begin
        if (at_end || !hex_nibble(b, d)) begin
          put_byte(16'h0, ST_BAD_HEX);
          dec_mode = MODE_IDLE;
        end else begin
          dec_acc  = {dec_acc[11:0], d};
          dec_ndig = dec_ndig + 3'd1;
          if (dec_ndig >= (dec_is_u ? 3'd4 : 3'd2)) begin
            if (dec_is_u) put_utf8(dec_acc);
            else put_byte({8'h00, dec_acc[7:0]}, ST_DATA);
            dec_mode = MODE_STR;
          end
        end
      end
      MODE_OCT: begin
        if (at_end) begin
          // The pending octal value still goes out before the error.
          put_utf8(dec_acc);
          put_byte(16'h0, ST_UNTERM);
          dec_mode = MODE_IDLE;
        end else if (b >= "0" && b <= "7" && dec_ndig < 3'd3) begin
          dec_acc  = {dec_acc[12:0], b[2:0]};
          dec_ndig = dec_ndig + 3'd1;
          if (dec_ndig >= 3'd3) begin
            put_utf8(dec_acc);
            dec_mode = MODE_STR;
          end
        end else begin
          // A byte that ends the octal run is then handled as a string byte.
          put_utf8(dec_acc);
          dec_mode = MODE_STR;
          string_char(b);
        end
      end
      default: begin
        dec_mode = MODE_IDLE;
        if (!at_end && (b == CH_DQUOTE || b == CH_SQUOTE)) begin
          dec_single = (b == CH_SQUOTE);
          dec_mode   = MODE_STR;
        end
      end
    endcase
    if (step_bytes.size() > 0) step_bytes[step_bytes.size()-1].last_of_run = 1'b1;
    decoded_q = {decoded_q, step_bytes};
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------

  function automatic void queue_byte(input logic [7:0] b);
    pending_req_t p;
    p.req.kind    = KIND_DATA;
    p.req.in_byte = b;
    p.hold_until_drained = 1'b0;
    pending_q = {pending_q, p};
  endfunction

  // End of data; the byte field is ignored, so it carries noise.
  function automatic void queue_end();
    pending_req_t p;
    p.req.kind    = KIND_END;
    p.req.in_byte = 8'($urandom_range(255));
    p.hold_until_drained = 1'b0;
    pending_q = {pending_q, p};
  endfunction

  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'("0" + v);
    return 8'(($urandom_range(1) ? "A" : "a") + v - 10);
  endfunction

  function automatic void queue_hex(input logic [15:0] v, input int digits);
    for (int i = digits - 1; i >= 0; i--) queue_byte(hex_char(v[i*4 +: 4]));
  endfunction

  function automatic bit in_list(input logic [7:0] b, input string s);
    for (int i = 0; i < s.len(); i++)
      if (s[i] == b) return 1'b1;
    return 1'b0;
  endfunction

  // Any byte that neither closes the string nor opens an escape.
  function automatic logic [7:0] plain_char(input logic [7:0] quote);
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == quote || c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [3:0] d;
    do c = 8'($urandom_range(255)); while (hex_nibble(c, d));
    return c;
  endfunction

  // Code points spread over the one, two and three byte UTF-8 ranges.
  function automatic logic [15:0] code_point();
    case ($urandom_range(2))
      0: return 16'($urandom_range(16'h007F));
      1: return 16'($urandom_range(16'h07FF, 16'h0080));
      default: return 16'($urandom_range(16'hFFFF, 16'h0800));
    endcase
  endfunction

  // One quoted string with random content, mostly closed
  // properly and sometimes cut short or broken inside an escape.
  function automatic void queue_string();
    logic [7:0] quote;
    logic [7:0] c;
    int         sel;
    int         segs;
    quote = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
    queue_byte(quote);
    segs = $urandom_range(6);
    for (int s = 0; s < segs; s++) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        queue_byte(plain_char(quote));
      end else begin
        queue_byte(CH_BSLASH);
        if (sel < 50) begin
          queue_byte(NAMED_ESC[$urandom_range(NAMED_ESC.len() - 1)]);
        end else if (sel < 65) begin
          queue_byte(ESC_UNICODE);
          queue_hex(code_point(), 4);
        end else if (sel < 75) begin
          queue_byte(ESC_RAW);
          queue_hex(16'($urandom_range(255)), 2);
        end else if (sel < 90) begin
          repeat ($urandom_range(3, 1)) queue_byte(8'("0" + $urandom_range(7)));
        end else begin
          do c = 8'($urandom_range(255)); while (in_list(c, KNOWN_ESC));
          queue_byte(c);
        end
      end
    end
    sel = $urandom_range(99);
    if (sel < 80) begin
      queue_byte(quote);
    end else if (sel < 86) begin
      queue_end();
    end else if (sel < 94) begin
      // Hex escape broken by a bad digit or by the end of data.
      queue_byte(CH_BSLASH);
      queue_byte($urandom_range(1) ? ESC_UNICODE : ESC_RAW);
      queue_hex(16'($urandom_range(255)), $urandom_range(1));
      if ($urandom_range(1)) queue_byte(non_hex_char());
      else queue_end();
    end else begin
      // End of data right after a backslash or inside an octal run.
      queue_byte(CH_BSLASH);
      if ($urandom_range(1)) queue_byte(8'("0" + $urandom_range(7)));
      queue_end();
    end
  endfunction

  // ---------------------------------------------------------------------
  // Handshake pacing
  // ---------------------------------------------------------------------

  // The run cycles through four pacing phases, stepped by how many requests
  // have gone in: free running, sender gaps, receiver stalls, then both.
  function automatic int pacing_phase();
    return (accepted_cnt / 55) % 4;
  endfunction

  function automatic int sender_gap_pct();
    case (pacing_phase())
      1: return 48;
      3: return 10;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case (pacing_phase())
      2: return 48;
      3: return 10;
      default: return 0;
    endcase
  endfunction

  // Sender: inputs change on the falling edge. A new request is only put up
  // once the previous one was taken, so a held request never changes.
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || req_taken) begin
      if (pending_q.size() != 0 &&
          !(pending_q[0].hold_until_drained && decoded_q.size() != 0) &&
          $urandom_range(99) >= sender_gap_pct()) begin
        item       <= pending_q[0].req;
        item_valid <= 1'b1;
        void'(pending_q.pop_front());
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, independent of what the block is offering.
  always @(negedge clk) begin
    if (rst) result_stall <= 1'b0;
    else result_stall <= ($urandom_range(99) < receiver_stall_pct());
  end

  // ---------------------------------------------------------------------
  // Monitor and scoreboard
  // ---------------------------------------------------------------------

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failures++;
    end
  endfunction

  // Both handshakes are sampled on the rising edge. Predictions for an
  // accepted request go in before the result check, though the block cannot
  // answer in the same cycle anyway.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      req_taken  <= 1'b0;
      dec_mode   = MODE_IDLE;
      dec_single = 1'b0;
      dec_ndig   = '0;
      dec_acc    = '0;
      dec_is_u   = 1'b0;
    end else begin
      req_taken <= item_valid && !item_stall;
      if (item_valid && !item_stall) begin
        decode_request(item);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (result_valid && !result_stall) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte %0h status %0d last %0d",
                   $time, result.out_byte, result.status, result.last_of_run);
          failures++;
        end else begin
          want = decoded_q.pop_front();
          check_field("out_byte", want.out_byte, result.out_byte);
          check_field("status", want.status, result.status);
          check_field("last_of_run", want.last_of_run, result.last_of_run);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------

  initial begin
    int first;
    int nstr;

    // Directed part. Junk and end of data in idle are both ignored.
    queue_text("z");
    queue_end();
    // Single-quoted string: the escaped double quote keeps its backslash,
    // the escaped single quote does not.
    queue_text("'\\\"\\''");
    // Largest code point in mixed-case hex, a three-digit octal escape that
    // needs two bytes and emits at once, a plain digit after it, and end of
    // data inside an octal run.
    queue_text("\"\\uFfFf\\3777\\1");
    queue_end();
    // End of data inside a raw hex escape.
    queue_text("\"\\x");
    queue_end();

    // Random part: mostly well-formed strings, with some idle noise between.
    nstr = 0;
    while (pending_q.size() < 210) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(2, 1)) begin
          if ($urandom_range(3) == 0) queue_end();
          else queue_byte(8'($urandom_range(255)));
        end
      end
      first = pending_q.size();
      queue_string();
      // Now and then let the block drain completely before the next string.
      if (nstr % 8 == 4) pending_q[first].hold_until_drained = 1'b1;
      nstr++;
    end
    total_reqs = pending_q.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted_cnt < total_reqs) @(negedge clk);
    while (decoded_q.size() != 0) @(negedge clk);
    // Any stray result would still show up during this wait.
    repeat (8) @(negedge clk);

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
